// ----- sv/fcce_pkg.sv -----
// Shared types and constants of the FAT16 cluster chain engine.
package fcce_pkg;

  localparam logic [15:0] END_OF_CHAIN      = 16'hFFFF;
  localparam int          FIRST_DATA        = 2;
  localparam logic [3:0]  CLUSTER_LOG2_INIT = 4'd11;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_BAD      = 2'd3
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    calc;
    logic    clear_step;
    logic    scan_start;
    logic    scan_run;
    logic    link_run;
    logic    term_wr;
    logic    free_start;
    logic    free_rd;
    logic    free_ev;
    logic    ent_rd;
    logic    ent_cap;
    logic    ent_wr;
    logic    load_out;
    status_t res_status;
  } fcce_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    need_zero;
    logic    need_big;
    logic    idx_bad;
    logic    head_bad;
    logic    clear_last;
    logic    last_hit;
    logic    exhausted;
    logic    link_eoc;
    logic    link_bad;
    logic    out_busy;
  } fcce_sts_t;

endpackage

// ----- sv/fat16_cluster_chain_engine.sv -----
// Top level of the FAT16 cluster chain engine: controller and datapath.
// After reset the table is cleared one entry per cycle, so the block accepts no transaction
// until every entry is clear; configuration writes are taken throughout. It then works on
// one transaction at a time. An entry read goes through the registered read of the table
// memory. Free walks the chain, clearing each entry that it visits up to the end marker, and
// stops at the first broken link, or at once for a bad head. Allocate scans the table up to
// twice, one entry per cycle: a counting pass that stops at the last cluster needed and a
// linking pass, or the counting pass alone when space runs out; a zero size or an oversized
// request ends without a scan. A result is held in an output register, and the next
// transaction is accepted while it waits; a later result waits until that register is free.
module fat16_cluster_chain_engine
  import fcce_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_CHAIN     = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_byte_size,
  input  logic [9:0]  in_start_cluster,
  input  logic [15:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [9:0]  out_first_cluster,
  output logic [10:0] out_chain_length,
  output logic [15:0] out_entry_read
);

  fcce_cmd_t cmd;
  fcce_sts_t sts;

  fcce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fcce_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CHAIN     (MAX_CHAIN)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_opcode         (in_opcode),
    .in_byte_size      (in_byte_size),
    .in_start_cluster  (in_start_cluster),
    .in_entry_value    (in_entry_value),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_first_cluster (out_first_cluster),
    .out_chain_length  (out_chain_length),
    .out_entry_read    (out_entry_read),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

// ----- sv/fcce_dp.sv -----
// Datapath of the FAT16 cluster chain engine: table memory, counters and result register.
module fcce_dp
  import fcce_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_CHAIN     = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_byte_size,
  input  logic [9:0]  in_start_cluster,
  input  logic [15:0] in_entry_value,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [9:0]  out_first_cluster,
  output logic [10:0] out_chain_length,
  output logic [15:0] out_entry_read,
  input  fcce_cmd_t   cmd,
  output fcce_sts_t   sts
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int AW    = IDX_W + 1;
  localparam int CNT_W = $clog2(MAX_CHAIN + 1);
  localparam int LEN_W = $clog2(TABLE_ENTRIES + 1);

  logic [15:0]      mem [TABLE_ENTRIES];
  logic [15:0]      rdata_r;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [15:0]      wdata;
  logic [IDX_W-1:0] raddr;

  logic [3:0]       csl_r;
  opcode_t          op_r;
  logic [31:0]      size_r;
  logic [9:0]       idx_r;
  logic [15:0]      val_r;

  logic [CNT_W-1:0] need_r;
  logic             need_zero_r;
  logic             need_big_r;
  logic [AW-1:0]    scan_addr_r;
  logic             pend_vld_r;
  logic [IDX_W-1:0] pend_addr_r;
  logic [CNT_W-1:0] hits_r;
  logic [IDX_W-1:0] prev_r;
  logic [IDX_W-1:0] first_r;
  logic [IDX_W-1:0] cur_r;
  logic [LEN_W-1:0] len_r;
  logic [15:0]      entry_r;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [9:0]       out_first_r;
  logic [10:0]      out_len_r;
  logic [15:0]      out_entry_r;

  logic [32:0]       mask33;
  logic [32:0]       sum33;
  logic [32:0]       need33;
  logic [IDX_W+9:0]  idx_ext;
  logic [IDX_W-1:0]  idx_addr;
  logic [IDX_W+15:0] next_ext;
  logic [IDX_W+15:0] link_ext;
  logic [IDX_W+9:0]  first_ext;
  logic [LEN_W+10:0] len_ext;
  logic              scan_more;
  logic              issue;
  logic              hit;
  logic              last_hit;
  logic              link_wr;
  logic              next_ok;

  assign mask33    = (33'd1 << csl_r) - 33'd1;
  assign sum33     = {1'b0, size_r} + mask33;
  assign need33    = sum33 >> csl_r;

  assign idx_ext   = {{IDX_W{1'b0}}, idx_r};
  assign idx_addr  = idx_ext[IDX_W-1:0];
  assign next_ext  = {{IDX_W{1'b0}}, rdata_r};
  assign link_ext  = {16'h0000, pend_addr_r};
  assign first_ext = {10'b0, first_r};
  assign len_ext   = {11'b0, len_r};

  assign scan_more = scan_addr_r < AW'(TABLE_ENTRIES);
  assign issue     = (cmd.scan_run || cmd.link_run) && scan_more && !cmd.scan_start;
  assign hit       = (cmd.scan_run || cmd.link_run) && pend_vld_r && (rdata_r == 16'h0000);
  assign last_hit  = hit && ((hits_r + CNT_W'(1)) == need_r);
  assign link_wr   = cmd.link_run && hit && (hits_r != '0);
  assign next_ok   = (32'(rdata_r) >= 32'(FIRST_DATA)) && (32'(rdata_r) < 32'(TABLE_ENTRIES));

  always_comb begin
    we    = 1'b0;
    waddr = scan_addr_r[IDX_W-1:0];
    wdata = 16'h0000;
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (link_wr) begin
      we    = 1'b1;
      waddr = prev_r;
      wdata = link_ext[15:0];
    end else if (cmd.term_wr) begin
      we    = 1'b1;
      waddr = prev_r;
      wdata = END_OF_CHAIN;
    end else if (cmd.free_ev) begin
      we    = 1'b1;
      waddr = cur_r;
    end else if (cmd.ent_wr) begin
      we    = 1'b1;
      waddr = idx_addr;
      wdata = val_r;
    end
  end

  always_comb begin
    if (cmd.free_rd) begin
      raddr = cur_r;
    end else if (cmd.ent_rd) begin
      raddr = idx_addr;
    end else begin
      raddr = scan_addr_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csl_r       <= CLUSTER_LOG2_INIT;
      scan_addr_r <= '0;
      pend_vld_r  <= 1'b0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        csl_r <= cfg_wdata;
      end
      if (cmd.scan_start) begin
        scan_addr_r <= AW'(FIRST_DATA);
        hits_r      <= '0;
      end else begin
        if (cmd.clear_step || issue) begin
          scan_addr_r <= scan_addr_r + AW'(1);
        end
        if (hit) begin
          hits_r <= hits_r + CNT_W'(1);
        end
      end
      pend_vld_r <= issue;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= scan_addr_r[IDX_W-1:0];
    if (cmd.capture) begin
      op_r    <= opcode_t'(in_opcode);
      size_r  <= in_byte_size;
      idx_r   <= in_start_cluster;
      val_r   <= in_entry_value;
      len_r   <= '0;
      first_r <= '0;
      entry_r <= 16'h0000;
    end
    if (cmd.calc) begin
      need_r      <= need33[CNT_W-1:0];
      need_zero_r <= (need33 == 33'd0);
      need_big_r  <= (need33 > 33'(MAX_CHAIN));
    end
    if (cmd.link_run && hit) begin
      prev_r <= pend_addr_r;
      len_r  <= len_r + LEN_W'(1);
      if (hits_r == '0) begin
        first_r <= pend_addr_r;
      end
    end
    if (cmd.free_start) begin
      cur_r <= idx_addr;
    end
    if (cmd.free_ev) begin
      cur_r <= next_ext[IDX_W-1:0];
      len_r <= len_r + LEN_W'(1);
    end
    if (cmd.ent_cap) begin
      entry_r <= rdata_r;
    end
    if (cmd.load_out) begin
      out_status_r <= cmd.res_status;
      out_first_r  <= first_ext[9:0];
      out_len_r    <= len_ext[10:0];
      out_entry_r  <= entry_r;
    end
  end

  assign sts.op         = op_r;
  assign sts.need_zero  = need_zero_r;
  assign sts.need_big   = need_big_r;
  assign sts.idx_bad    = 32'(idx_r) >= 32'(TABLE_ENTRIES);
  assign sts.head_bad   = (32'(idx_r) < 32'(FIRST_DATA)) || (32'(idx_r) >= 32'(TABLE_ENTRIES));
  assign sts.clear_last = scan_addr_r == AW'(TABLE_ENTRIES - 1);
  assign sts.last_hit   = last_hit;
  assign sts.exhausted  = !scan_more && !pend_vld_r;
  assign sts.link_eoc   = rdata_r == END_OF_CHAIN;
  assign sts.link_bad   = (rdata_r != END_OF_CHAIN) && !next_ok;
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_first_cluster = out_first_r;
  assign out_chain_length  = out_len_r;
  assign out_entry_read    = out_entry_r;

  a_link_behind: assert property (@(posedge clk) disable iff (!rst_n)
    link_wr |-> prev_r < pend_addr_r)
    else $error("chain link written at or ahead of the scan position");

  a_hits_below_need: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_run || cmd.link_run) |-> hits_r < need_r)
    else $error("scan continued after enough free clusters were found");

  a_term_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.term_wr |-> hits_r == need_r)
    else $error("chain terminated with the wrong number of clusters");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before its transaction");

endmodule

// ----- sv/fcce_ctrl.sv -----
// Controller state machine of the FAT16 cluster chain engine.
module fcce_ctrl
  import fcce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fcce_sts_t sts,
  output fcce_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_CALC     = 12'b0000_0000_0100,
    S_PLAN     = 12'b0000_0000_1000,
    S_COUNT    = 12'b0000_0001_0000,
    S_LINK     = 12'b0000_0010_0000,
    S_TERM     = 12'b0000_0100_0000,
    S_FREE_RD  = 12'b0000_1000_0000,
    S_FREE_EV  = 12'b0001_0000_0000,
    S_ENT_RD   = 12'b0010_0000_0000,
    S_ENT_WAIT = 12'b0100_0000_0000,
    S_RESP     = 12'b1000_0000_0000
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  status_t st_r;
  status_t st_nxt;

  always_comb begin
    cmd            = '0;
    cmd.res_status = st_r;
    state_nxt      = state_r;
    st_nxt         = st_r;
    in_ready       = (state_r == S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        case (sts.op)
          OP_ALLOC: begin
            cmd.calc  = 1'b1;
            state_nxt = S_PLAN;
          end
          OP_FREE: begin
            if (sts.head_bad) begin
              st_nxt    = ST_BAD;
              state_nxt = S_RESP;
            end else begin
              cmd.free_start = 1'b1;
              state_nxt      = S_FREE_RD;
            end
          end
          OP_READ: begin
            if (sts.idx_bad) begin
              st_nxt    = ST_BAD;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_ENT_RD;
            end
          end
          OP_WRITE: begin
            if (sts.idx_bad) begin
              st_nxt = ST_BAD;
            end else begin
              cmd.ent_wr = 1'b1;
              st_nxt     = ST_OK;
            end
            state_nxt = S_RESP;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_PLAN: begin
        if (sts.need_zero) begin
          st_nxt    = ST_OK;
          state_nxt = S_RESP;
        end else if (sts.need_big) begin
          st_nxt    = ST_TOO_LONG;
          state_nxt = S_RESP;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.scan_run = 1'b1;
        if (sts.last_hit) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_LINK;
        end else if (sts.exhausted) begin
          st_nxt    = ST_NO_SPACE;
          state_nxt = S_RESP;
        end
      end
      S_LINK: begin
        cmd.link_run = 1'b1;
        if (sts.last_hit) begin
          state_nxt = S_TERM;
        end
      end
      S_TERM: begin
        cmd.term_wr = 1'b1;
        st_nxt      = ST_OK;
        state_nxt   = S_RESP;
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FREE_EV;
      end
      S_FREE_EV: begin
        if (sts.link_bad) begin
          st_nxt    = ST_BAD;
          state_nxt = S_RESP;
        end else begin
          cmd.free_ev = 1'b1;
          if (sts.link_eoc) begin
            st_nxt    = ST_OK;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_FREE_RD;
          end
        end
      end
      S_ENT_RD: begin
        cmd.ent_rd = 1'b1;
        state_nxt  = S_ENT_WAIT;
      end
      S_ENT_WAIT: begin
        cmd.ent_cap = 1'b1;
        st_nxt      = ST_OK;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

// ----- sim/fat16_cluster_chain_engine_test.sv -----
// Self-checking testbench for the FAT16 cluster chain engine, with a shadow allocation table.
module fat16_cluster_chain_engine_test
  import fcce_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FAT_ENTRIES = 1024;
  localparam int CHAIN_MAX = 128;
  localparam int STUCK_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 2200;
  localparam int PHASE_ITEMS = 33;

  typedef struct packed {
    opcode_t     op;
    logic [31:0] size;
    logic [9:0]  cluster;
    logic [15:0] value;
  } fat_req_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  first;
    logic [10:0] length;
    logic [15:0] entry;
  } fat_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = CLUSTER_LOG2_INIT;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = OP_READ;
  logic [31:0] in_byte_size = '0;
  logic [9:0]  in_start_cluster = '0;
  logic [15:0] in_entry_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [9:0]  out_first_cluster;
  logic [10:0] out_chain_length;
  logic [15:0] out_entry_read;

  fat_req_t    req_backlog[$];
  fat_resp_t   predicted_resp[$];
  int          live_chains[$];
  logic [15:0] fat_shadow [0:FAT_ENTRIES-1];
  logic [3:0]  shadow_log2 = CLUSTER_LOG2_INIT;
  logic [3:0]  log2_plan [0:7] = '{4'd9, 4'd15, 4'd5, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11};

  fat_req_t    cur_req;
  fat_resp_t   got_resp;
  fat_resp_t   want_resp;
  int          burst_left = 0;
  int          gap_left = 0;
  int          ready_run = 0;
  int          stuck_cycles = 0;
  int          fail_count = 0;

  fat16_cluster_chain_engine #(
    .TABLE_ENTRIES(FAT_ENTRIES),
    .MAX_CHAIN(CHAIN_MAX)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_byte_size(in_byte_size),
    .in_start_cluster(in_start_cluster),
    .in_entry_value(in_entry_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_first_cluster(out_first_cluster),
    .out_chain_length(out_chain_length),
    .out_entry_read(out_entry_read)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic fat_resp_t fat_apply(fat_req_t req);
    fat_resp_t   r;
    logic [33:0] mask;
    logic [33:0] need;
    int          picked [0:CHAIN_MAX-1];
    int          got;
    int          i;
    int          cur;
    int          count;
    logic [15:0] nxt;
    bit          walking;
    r = '0;
    r.status = ST_OK;
    case (req.op)
      OP_ALLOC: begin
        mask = (34'd1 << shadow_log2) - 34'd1;
        need = ({2'b00, req.size} + mask) >> shadow_log2;
        if (need > CHAIN_MAX) begin
          r.status = ST_TOO_LONG;
        end else if (need != 0) begin
          got = 0;
          for (i = FIRST_DATA; i < FAT_ENTRIES && got < need; i++) begin
            if (fat_shadow[i] == 16'h0000) begin
              picked[got] = i;
              got++;
            end
          end
          if (got < need) begin
            r.status = ST_NO_SPACE;
          end else begin
            for (i = 0; i + 1 < got; i++) fat_shadow[picked[i]] = 16'(picked[i + 1]);
            fat_shadow[picked[got - 1]] = END_OF_CHAIN;
            r.first = 10'(picked[0]);
            r.length = 11'(got);
            live_chains.push_back(picked[0]);
          end
        end
      end
      OP_FREE: begin
        if (req.cluster < FIRST_DATA) begin
          r.status = ST_BAD;
        end else begin
          cur = req.cluster;
          count = 0;
          walking = 1'b1;
          while (walking) begin
            nxt = fat_shadow[cur];
            if (nxt != END_OF_CHAIN && (nxt < FIRST_DATA || nxt >= FAT_ENTRIES)) begin
              r.status = ST_BAD;
              walking = 1'b0;
            end else begin
              fat_shadow[cur] = 16'h0000;
              count++;
              if (nxt == END_OF_CHAIN) walking = 1'b0;
              else cur = nxt;
            end
          end
          r.length = 11'(count);
          i = 0;
          while (i < live_chains.size()) begin
            if (live_chains[i] == req.cluster) live_chains.delete(i);
            else i++;
          end
        end
      end
      OP_READ: begin
        r.entry = fat_shadow[req.cluster];
      end
      default: begin
        fat_shadow[req.cluster] = req.value;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      foreach (fat_shadow[k]) fat_shadow[k] = 16'h0000;
    end else begin
      if (in_valid && in_ready) predicted_resp.push_back(fat_apply(cur_req));
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          cur_req = req_backlog.pop_front();
          in_valid <= 1'b1;
          in_opcode <= cur_req.op;
          in_byte_size <= cur_req.size;
          in_start_cluster <= cur_req.cluster;
          in_entry_value <= cur_req.value;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_run <= 0;
      shadow_log2 <= CLUSTER_LOG2_INIT;
    end else begin
      if (cfg_we) shadow_log2 <= cfg_wdata;
      if (ready_run != 0) begin
        ready_run <= ready_run - 1;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_ready <= 1'b1;
            ready_run <= $urandom_range(50, 300);
          end
          1: begin
            out_ready <= 1'b0;
            ready_run <= $urandom_range(1, 40);
          end
          default: begin
            out_ready <= ~out_ready;
            ready_run <= $urandom_range(0, 7);
          end
        endcase
      end
      if (out_valid && out_ready) begin
        got_resp = {status_t'(out_status), out_first_cluster, out_chain_length, out_entry_read};
        if (predicted_resp.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t ns: result transaction with none expected, got status %0d first %0d"
                   , $time, got_resp.status, got_resp.first,
                   " length %0d entry %h", got_resp.length, got_resp.entry);
        end else begin
          want_resp = predicted_resp.pop_front();
          if (got_resp !== want_resp) begin
            fail_count <= fail_count + 1;
            $display("%0t ns: expected status %0d first %0d length %0d entry %h", $time,
                     want_resp.status, want_resp.first, want_resp.length, want_resp.entry);
            $display("%0t ns: actual   status %0d first %0d length %0d entry %h", $time,
                     got_resp.status, got_resp.first, got_resp.length, got_resp.entry);
          end
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic submit(opcode_t op, logic [31:0] size, logic [9:0] cl, logic [15:0] val);
    while (req_backlog.size() > 1) @(negedge clk);
    req_backlog.push_back('{op: op, size: size, cluster: cl, value: val});
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid || predicted_resp.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] bytes_for(int unsigned clusters);
    return 32'(((clusters - 1) << shadow_log2) + $urandom_range(1, 1 << shadow_log2));
  endfunction

  function automatic logic [9:0] pick_cluster(bit prefer_live);
    if (prefer_live && live_chains.size() != 0)
      return 10'(live_chains[$urandom_range(0, live_chains.size() - 1)]);
    return 10'($urandom_range(0, FAT_ENTRIES - 1));
  endfunction

  initial begin
    int          ph;
    int          n;
    int          pick;
    logic [31:0] sz;
    logic [9:0]  cl;
    logic [15:0] v;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    submit(OP_ALLOC, 32'd0, 10'd0, 16'h0000);
    submit(OP_ALLOC, 32'hFFFF_FFFF, 10'd1023, 16'hFFFF);
    submit(OP_ALLOC, 32'd1, 10'd0, 16'h0000);
    submit(OP_ALLOC, 32'(CHAIN_MAX) << CLUSTER_LOG2_INIT, 10'd0, 16'h0000);
    submit(OP_ALLOC, (32'(CHAIN_MAX) << CLUSTER_LOG2_INIT) + 32'd1, 10'd0, 16'h0000);
    submit(OP_WRITE, 32'hFFFF_FFFF, 10'd1023, 16'hFFFF);
    submit(OP_READ, 32'd0, 10'd1023, 16'h0000);
    submit(OP_READ, 32'd0, 10'd0, 16'h0000);
    submit(OP_FREE, 32'd0, 10'd0, 16'h0000);
    submit(OP_FREE, 32'd0, 10'd1, 16'h0000);
    submit(OP_FREE, 32'd0, 10'd2, 16'h0000);
    // A reserved end marker other than all ones counts as a broken link.
    submit(OP_WRITE, 32'd0, 10'd10, 16'hFFF8);
    submit(OP_FREE, 32'd0, 10'd3, 16'h0000);
    submit(OP_FREE, 32'd0, 10'd11, 16'h0000);
    submit(OP_WRITE, 32'd0, 10'd10, 16'h0000);
    submit(OP_WRITE, 32'd0, 10'd500, 16'd501);
    submit(OP_WRITE, 32'd0, 10'd501, 16'd500);
    submit(OP_FREE, 32'd0, 10'd500, 16'h0000);
    for (n = 0; n < 7; n++) submit(OP_ALLOC, 32'(CHAIN_MAX) << CLUSTER_LOG2_INIT, 10'd0, 16'h0);
    submit(OP_ALLOC, 32'd126 << CLUSTER_LOG2_INIT, 10'd0, 16'h0000);

    for (ph = 0; ph < 8; ph++) begin
      wait_drained();
      repeat (4) @(negedge clk);
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= log2_plan[ph];
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && ph % 3 == 1) wait_drained();
        pick = $urandom_range(0, 99);
        v = 16'($urandom_range(0, 65535));
        if (pick < 40) begin
          pick = $urandom_range(0, 99);
          if (pick < 8) sz = 32'd0;
          else if (pick < 14) sz = $urandom();
          else if (pick < 22) sz = bytes_for($urandom_range(64, CHAIN_MAX));
          else sz = bytes_for($urandom_range(1, 6));
          submit(OP_ALLOC, sz, pick_cluster(1'b0), v);
        end else if (pick < 70) begin
          submit(OP_FREE, $urandom(), pick_cluster(pick < 66), v);
        end else if (pick < 82) begin
          submit(OP_READ, $urandom(), pick_cluster(pick < 76), v);
        end else begin
          cl = pick_cluster(pick < 90);
          case ($urandom_range(0, 3))
            0: v = 16'h0000;
            1: v = 16'(pick_cluster(1'b1));
            2: v = END_OF_CHAIN;
            default: ;
          endcase
          submit(OP_WRITE, $urandom(), cl, v);
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && predicted_resp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
